@@ rtl/core/wsdf_pkg.sv @@
// shared types, codes and helpers for the websocket frame deframer
package wsdf_pkg;

	// result status codes
	localparam logic [2:0] ST_DATA    = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_HDR_ERR = 3'd2;
	localparam logic [2:0] ST_LEN_ERR = 3'd3;
	localparam logic [2:0] ST_OP_ERR  = 3'd4;

	// length codes in the 7-bit length field
	localparam logic [6:0] LEN7_EXT16 = 7'h7E;
	localparam logic [6:0] LEN7_EXT64 = 7'h7F;

	// supported opcodes
	localparam logic [3:0] OP_TEXT   = 4'd1;
	localparam logic [3:0] OP_BINARY = 4'd2;
	localparam logic [3:0] OP_CLOSE  = 4'd8;
	localparam logic [3:0] OP_PING   = 4'd9;
	localparam logic [3:0] OP_PONG   = 4'd10;

	// one result item
	typedef struct packed {
		logic [7:0] data_byte;
		logic [3:0] frame_type;
		logic [2:0] status;
		logic       last;
	} wsdf_result_t;

	// true for the opcodes the deframer accepts
	function automatic logic opcode_ok(input logic [3:0] op);
		return (op == OP_TEXT) || (op == OP_BINARY) || (op == OP_CLOSE) ||
			(op == OP_PING) || (op == OP_PONG);
	endfunction

endpackage

@@ rtl/core/wsdf_byte_if.sv @@
// raw byte stream channel
interface wsdf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

@@ rtl/core/wsdf_result_if.sv @@
// deframed result channel
interface wsdf_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [3:0] frame_type;
	logic [2:0] status;
	logic       last;

	modport source (output valid, output data_byte, output frame_type, output status,
		output last, input ready);
	modport sink (input valid, input data_byte, input frame_type, input status,
		input last, output ready);
endinterface

@@ rtl/core/wsdf_parser.sv @@
// frame header parser, length and key capture, payload unmasking
module wsdf_parser
	import wsdf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   raw_byte,
	input  logic         expect_masked,
	output logic         res_valid,
	output wsdf_result_t res
);

	localparam logic [2:0] PH_HDR0 = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_KEY  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic [3:0]  ext_left_q, ext_left_d;
	logic [63:0] remaining_q, remaining_d;
	logic [31:0] key_q, key_d;
	logic [2:0]  key_left_q, key_left_d;
	logic [1:0]  mask_phase_q, mask_phase_d;
	logic        masked_q, masked_d;
	logic        error_q, error_d;

	logic        len_done;
	logic [7:0]  key_byte;
	logic [63:0] remaining_dec;

	assign remaining_dec = remaining_q - 64'd1;

	// key byte for this payload position, first received key byte first
	always_comb begin
		unique case (mask_phase_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next state and result for one byte
	always_comb begin
		phase_d      = phase_q;
		opcode_d     = opcode_q;
		ext_left_d   = ext_left_q;
		remaining_d  = remaining_q;
		key_d        = key_q;
		key_left_d   = key_left_q;
		mask_phase_d = mask_phase_q;
		masked_d     = masked_q;
		error_d      = error_q;
		len_done     = 1'b0;
		res_valid    = 1'b0;
		res          = '0;

		if (step && !error_q) begin
			unique case (phase_q)
				PH_HDR0: begin
					opcode_d = raw_byte[3:0];
					if (!raw_byte[7] || (raw_byte[6:4] != 3'd0)) begin
						error_d   = 1'b1;
						res_valid = 1'b1;
						res.status = ST_HDR_ERR;
						res.last  = 1'b1;
					end else begin
						phase_d = PH_HDR1;
					end
				end
				PH_HDR1: begin
					masked_d = raw_byte[7];
					if (raw_byte[7] != expect_masked) begin
						error_d   = 1'b1;
						phase_d   = PH_HDR0;
						res_valid = 1'b1;
						res.status = ST_HDR_ERR;
						res.last  = 1'b1;
					end else if (raw_byte[6:0] == LEN7_EXT16) begin
						remaining_d = '0;
						ext_left_d  = 4'd2;
						phase_d     = PH_EXT;
					end else if (raw_byte[6:0] == LEN7_EXT64) begin
						remaining_d = '0;
						ext_left_d  = 4'd8;
						phase_d     = PH_EXT;
					end else begin
						remaining_d = {57'd0, raw_byte[6:0]};
						len_done    = 1'b1;
					end
				end
				PH_EXT: begin
					if ((ext_left_q == 4'd8) && raw_byte[7]) begin
						error_d   = 1'b1;
						phase_d   = PH_HDR0;
						res_valid = 1'b1;
						res.status = ST_LEN_ERR;
						res.last  = 1'b1;
					end else begin
						remaining_d = {remaining_q[55:0], raw_byte};
						ext_left_d  = ext_left_q - 4'd1;
						len_done    = (ext_left_q == 4'd1);
					end
				end
				PH_KEY: begin
					key_d      = {key_q[23:0], raw_byte};
					key_left_d = key_left_q - 3'd1;
					if (key_left_q == 3'd1) begin
						if (remaining_q == 64'd0) begin
							phase_d    = PH_HDR0;
							res_valid  = 1'b1;
							res.status = ST_EMPTY;
							res.last   = 1'b1;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					mask_phase_d  = mask_phase_q + 2'd1;
					remaining_d   = remaining_dec;
					res_valid     = 1'b1;
					res.data_byte = masked_q ? (raw_byte ^ key_byte) : raw_byte;
					res.status    = ST_DATA;
					if (remaining_dec == 64'd0) begin
						phase_d  = PH_HDR0;
						res.last = 1'b1;
					end
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase

			// length complete: opcode check, then key, payload or empty end
			if (len_done) begin
				if (!opcode_ok(opcode_q)) begin
					error_d    = 1'b1;
					phase_d    = PH_HDR0;
					res_valid  = 1'b1;
					res.status = ST_OP_ERR;
					res.last   = 1'b1;
				end else begin
					mask_phase_d = 2'd0;
					if (masked_d) begin
						key_d      = '0;
						key_left_d = 3'd4;
						phase_d    = PH_KEY;
					end else if (remaining_d == 64'd0) begin
						phase_d    = PH_HDR0;
						res_valid  = 1'b1;
						res.status = ST_EMPTY;
						res.last   = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			res.frame_type = opcode_d;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR0;
			opcode_q     <= '0;
			ext_left_q   <= '0;
			remaining_q  <= '0;
			key_q        <= '0;
			key_left_q   <= '0;
			mask_phase_q <= '0;
			masked_q     <= 1'b0;
			error_q      <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			opcode_q     <= opcode_d;
			ext_left_q   <= ext_left_d;
			remaining_q  <= remaining_d;
			key_q        <= key_d;
			key_left_q   <= key_left_d;
			mask_phase_q <= mask_phase_d;
			masked_q     <= masked_d;
			error_q      <= error_d;
		end
	end

endmodule

@@ rtl/core/websocket_frame_deframer.sv @@
// top level of the websocket frame deframer
//
//   port           dir   contents
//   frame_in       sink  in_byte, one raw stream byte per transfer
//   frame_out      src   data_byte, frame_type, status, last
//   cfg_wr_en/data in    expect_masked register write
//
// One byte per cycle sustained while the output is not stalled; a byte is held in
// the input register and is parsed into the result register, from which its result
// is offered. The 64-bit length counter decrement and compare is the longest path.
// Reset clears all parser state and sets expect_masked. A stalled output holds the
// result register and then the input register; a byte waits on a held result
// register even when it gives no result.
module websocket_frame_deframer
	import wsdf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	wsdf_byte_if.sink     frame_in,
	wsdf_result_if.source frame_out,
	input  logic   cfg_wr_en,
	input  logic   cfg_wr_data
);

	logic         expect_masked_q;
	logic [7:0]   byte_s1;
	logic         valid_s1;
	logic         advance;
	logic         res_valid;
	wsdf_result_t res;
	wsdf_result_t out_q;
	logic         out_valid_q;

	// byte in the input register moves on when the result slot is free
	assign advance        = valid_s1 && (!out_valid_q || frame_out.ready);
	assign frame_in.ready = !valid_s1 || advance;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_masked_q <= 1'b1;
		end else if (cfg_wr_en) begin
			expect_masked_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_in.ready) begin
			valid_s1 <= frame_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_in.valid && frame_in.ready) begin
			byte_s1 <= frame_in.in_byte;
		end
	end

	wsdf_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.raw_byte      (byte_s1),
		.expect_masked (expect_masked_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (frame_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign frame_out.valid      = out_valid_q;
	assign frame_out.data_byte  = out_q.data_byte;
	assign frame_out.frame_type = out_q.frame_type;
	assign frame_out.status     = out_q.status;
	assign frame_out.last       = out_q.last;

endmodule

@@ tb/tb.sv @@
// testbench for the websocket frame deframer: random and directed frame streams
`timescale 1ns / 1ps

module tb;
	import wsdf_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned SETTLE_CYCLES = 8;

	// parser position inside a frame
	typedef enum logic [2:0] {
		AWAIT_HDR0,
		AWAIT_HDR1,
		AWAIT_EXT_LEN,
		AWAIT_KEY,
		AWAIT_PAYLOAD
	} parse_phase_t;

	// length encodings in the second header byte
	typedef enum logic [1:0] {LEN_SHORT, LEN_MID, LEN_LONG} len_form_t;

	// ways to break a frame header
	typedef enum logic [2:0] {F_NO_FIN, F_RSV, F_MASK_BIT, F_HUGE_LEN, F_BAD_OP} fault_kind_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	wsdf_byte_if   frame_in_if ();
	wsdf_result_if frame_out_if ();

	websocket_frame_deframer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_in    (frame_in_if),
		.frame_out   (frame_out_if),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	localparam logic [3:0] GOOD_OPS [5] = '{OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};

	// stimulus and expected results
	logic [7:0]   stream_bytes [$];
	logic [7:0]   frame_buf [$];
	wsdf_result_t expected_results [$];
	int unsigned  errors = 0;
	int unsigned  cycle_count = 0;

	// handshake pressure knobs
	int unsigned send_idle_pct = 28;
	int unsigned recv_idle_pct = 81;
	int unsigned hold_requests = 0;
	int unsigned holds_served;
	int unsigned hold_left;

	// predicted parser state
	logic         want_masked = 1'b1;
	parse_phase_t parse_phase = AWAIT_HDR0;
	logic [3:0]   op_held = 4'd0;
	logic [3:0]   ext_left = 4'd0;
	logic [63:0]  remaining = 64'd0;
	logic [31:0]  key = 32'd0;
	logic [2:0]   key_left = 3'd0;
	logic [1:0]   key_idx = 2'd0;
	logic         frame_masked = 1'b0;
	logic         stuck = 1'b0;

	wsdf_result_t got;
	wsdf_result_t want;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reset, asserted once
	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// append one byte to the pending stream
	function automatic void add_stream_byte(input logic [7:0] b);
		stream_bytes.insert(stream_bytes.size(), b);
	endfunction

	// append one byte to the frame being built
	function automatic void add_frame_byte(input logic [7:0] b);
		frame_buf.insert(frame_buf.size(), b);
	endfunction

	function automatic void queue_result(input logic [7:0] data, input logic [2:0] st,
			input logic lst);
		wsdf_result_t r;
		r = '{data_byte: data, frame_type: op_held, status: st, last: lst};
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void raise_fault(input logic [2:0] st);
		stuck = 1'b1;
		parse_phase = AWAIT_HDR0;
		queue_result(8'h00, st, 1'b1);
	endfunction

	// length known: opcode check, then key, payload or empty frame end
	function automatic void length_complete();
		if (!(op_held inside {OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG})) begin
			raise_fault(ST_OP_ERR);
			return;
		end
		key_idx = 2'd0;
		if (frame_masked) begin
			key = 32'd0;
			key_left = 3'd4;
			parse_phase = AWAIT_KEY;
		end else if (remaining == 64'd0) begin
			parse_phase = AWAIT_HDR0;
			queue_result(8'h00, ST_EMPTY, 1'b1);
		end else begin
			parse_phase = AWAIT_PAYLOAD;
		end
	endfunction

	// advance the predicted parser by one stream byte
	function automatic void deframe_byte(input logic [7:0] b);
		logic [7:0] k;
		if (stuck)
			return;
		case (parse_phase)
			AWAIT_HDR0: begin
				op_held = b[3:0];
				if (!b[7] || b[6:4] != 3'b000)
					raise_fault(ST_HDR_ERR);
				else
					parse_phase = AWAIT_HDR1;
			end
			AWAIT_HDR1: begin
				frame_masked = b[7];
				if (frame_masked != want_masked) begin
					raise_fault(ST_HDR_ERR);
				end else begin
					remaining = 64'd0;
					if (b[6:0] == LEN7_EXT16) begin
						ext_left = 4'd2;
						parse_phase = AWAIT_EXT_LEN;
					end else if (b[6:0] == LEN7_EXT64) begin
						ext_left = 4'd8;
						parse_phase = AWAIT_EXT_LEN;
					end else begin
						remaining = 64'(b[6:0]);
						length_complete();
					end
				end
			end
			AWAIT_EXT_LEN: begin
				if (ext_left == 4'd8 && b[7]) begin
					raise_fault(ST_LEN_ERR);
				end else begin
					remaining = {remaining[55:0], b};
					ext_left = ext_left - 4'd1;
					if (ext_left == 4'd0)
						length_complete();
				end
			end
			AWAIT_KEY: begin
				key = {key[23:0], b};
				key_left = key_left - 3'd1;
				if (key_left == 3'd0) begin
					if (remaining == 64'd0) begin
						parse_phase = AWAIT_HDR0;
						queue_result(8'h00, ST_EMPTY, 1'b1);
					end else begin
						parse_phase = AWAIT_PAYLOAD;
					end
				end
			end
			AWAIT_PAYLOAD: begin
				// first key byte received unmasks payload byte 0
				k = frame_masked ? key[8 * (3 - key_idx) +: 8] : 8'h00;
				key_idx = key_idx + 2'd1;
				remaining = remaining - 64'd1;
				if (remaining == 64'd0)
					parse_phase = AWAIT_HDR0;
				queue_result(b ^ k, ST_DATA, remaining == 64'd0);
			end
			default: begin
				parse_phase = AWAIT_HDR0;
			end
		endcase
	endfunction

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_in_if.valid <= 1'b0;
			frame_in_if.in_byte <= 8'h00;
		end else if (!frame_in_if.valid || frame_in_if.ready) begin
			if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				frame_in_if.valid <= 1'b1;
				frame_in_if.in_byte <= stream_bytes.pop_front();
			end else begin
				frame_in_if.valid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls and long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_out_if.ready <= 1'b0;
			hold_left <= 0;
			holds_served <= 0;
		end else if (hold_left != 0) begin
			frame_out_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_requests) begin
			holds_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			frame_out_if.ready <= 1'b0;
		end else begin
			frame_out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result check, register tracking and prediction per transfer
	always @(posedge clk) begin
		if (frame_out_if.valid && frame_out_if.ready) begin
			got = '{data_byte: frame_out_if.data_byte, frame_type: frame_out_if.frame_type,
				status: frame_out_if.status, last: frame_out_if.last};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none", $time);
				$display("%0t: got data %02h type %0d status %0d last %0b",
					$time, got.data_byte, got.frame_type, got.status, got.last);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.data_byte !== want.data_byte || got.frame_type !== want.frame_type ||
						got.status !== want.status || got.last !== want.last) begin
					$display("%0t: result mismatch, expected data %02h type %0d status %0d last %0b",
						$time, want.data_byte, want.frame_type, want.status, want.last);
					$display("%0t: got data %02h type %0d status %0d last %0b",
						$time, got.data_byte, got.frame_type, got.status, got.last);
					errors++;
				end
			end
		end
		if (cfg_wr_en)
			want_masked = cfg_wr_data;
		if (frame_in_if.valid && frame_in_if.ready)
			deframe_byte(frame_in_if.in_byte);
	end

	// build one well-formed frame into frame_buf
	function automatic void make_frame(input logic mask_on, input logic [3:0] op,
			input len_form_t form, input int unsigned len, input logic extremes);
		logic [31:0] mkey;
		logic [63:0] len64;
		mkey = extremes ? 32'h00FF00FF : $urandom();
		len64 = 64'(len);
		frame_buf.delete();
		add_frame_byte({4'b1000, op});
		case (form)
			LEN_SHORT: begin
				add_frame_byte({mask_on, len64[6:0]});
			end
			LEN_MID: begin
				add_frame_byte({mask_on, LEN7_EXT16});
				add_frame_byte(len64[15:8]);
				add_frame_byte(len64[7:0]);
			end
			default: begin
				add_frame_byte({mask_on, LEN7_EXT64});
				for (int i = 7; i >= 0; i--)
					add_frame_byte(len64[8 * i +: 8]);
			end
		endcase
		if (mask_on)
			for (int i = 3; i >= 0; i--)
				add_frame_byte(mkey[8 * i +: 8]);
		for (int i = 0; i < int'(len); i++)
			add_frame_byte(extremes ? {8{i[0]}} : 8'($urandom()));
	endfunction

	function automatic void send_frame_bytes(input int from, input int upto);
		for (int i = from; i < upto; i++)
			add_stream_byte(frame_buf[i]);
	endfunction

	// random frame, mostly short payloads, now and then long ones
	function automatic int unsigned queue_random_frame(input logic mask_on);
		int unsigned pick;
		int unsigned len;
		len_form_t form;
		pick = $urandom_range(99);
		if (pick < 58) begin
			form = LEN_SHORT;
			len = $urandom_range(10);
		end else if (pick < 68) begin
			form = LEN_SHORT;
			len = ($urandom_range(3) == 0) ? 125 : $urandom_range(40, 11);
		end else if (pick < 86) begin
			form = LEN_MID;
			len = ($urandom_range(9) == 0) ? $urandom_range(300, 126) : $urandom_range(24);
		end else begin
			form = LEN_LONG;
			len = $urandom_range(24);
		end
		make_frame(mask_on, GOOD_OPS[$urandom_range(4)], form, len, 1'b0);
		send_frame_bytes(0, frame_buf.size());
		return frame_buf.size();
	endfunction

	function automatic void queue_random_bytes(input logic mask_on, input int unsigned target);
		int unsigned count;
		count = 0;
		while (count < target)
			count += queue_random_frame(mask_on);
	endfunction

	// one broken frame, then bytes the block must discard
	function automatic void queue_fault(input logic mask_on);
		logic [3:0] op;
		op = GOOD_OPS[$urandom_range(4)];
		case (fault_kind_t'($urandom_range(4)))
			F_NO_FIN: begin
				add_stream_byte({1'b0, 7'($urandom_range(127))});
			end
			F_RSV: begin
				add_stream_byte({1'b1, 3'($urandom_range(7, 1)), op});
			end
			F_MASK_BIT: begin
				add_stream_byte({4'b1000, op});
				add_stream_byte({~mask_on, 7'($urandom_range(127))});
			end
			F_HUGE_LEN: begin
				add_stream_byte({4'b1000, op});
				add_stream_byte({mask_on, LEN7_EXT64});
				add_stream_byte({1'b1, 7'($urandom_range(127))});
			end
			default: begin
				do
					op = 4'($urandom_range(15));
				while (op inside {OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG});
				make_frame(mask_on, op, len_form_t'($urandom_range(2)), $urandom_range(6),
					1'b0);
				send_frame_bytes(0, frame_buf.size());
			end
		endcase
		repeat ($urandom_range(20, 8))
			add_stream_byte(8'($urandom()));
	endfunction

	// wait until every byte is sent and every result has come, then settle
	task automatic drain_results();
		@(negedge clk);
		while (stream_bytes.size() != 0 || frame_in_if.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_expect_masked(input logic value);
		drain_results();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// stimulus sequence
	initial begin
		logic tail_masked;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 1'b0;
		wait (arst_n === 1'b1);
		write_expect_masked(1'b1);

		// client frames: empty ping, extreme payload bytes, 16-bit length
		make_frame(1'b1, OP_PING, LEN_SHORT, 0, 1'b0);
		send_frame_bytes(0, frame_buf.size());
		make_frame(1'b1, OP_BINARY, LEN_SHORT, 2, 1'b1);
		send_frame_bytes(0, frame_buf.size());
		make_frame(1'b1, OP_TEXT, LEN_MID, 3, 1'b0);
		send_frame_bytes(0, frame_buf.size());

		// server frames: empty close, 64-bit length pong
		write_expect_masked(1'b0);
		make_frame(1'b0, OP_CLOSE, LEN_SHORT, 0, 1'b0);
		send_frame_bytes(0, frame_buf.size());
		make_frame(1'b0, OP_PONG, LEN_LONG, 1, 1'b1);
		send_frame_bytes(0, frame_buf.size());
		queue_random_bytes(1'b0, 130);

		// mode flips between the two header bytes of a frame
		make_frame(1'b1, GOOD_OPS[$urandom_range(4)], LEN_SHORT, 5, 1'b0);
		send_frame_bytes(0, 1);
		write_expect_masked(1'b1);
		send_frame_bytes(1, frame_buf.size());

		send_idle_pct = 81;
		recv_idle_pct = 28;
		queue_random_bytes(1'b1, 140);

		// no idling, long receiver hold-off while the stream keeps coming
		write_expect_masked(1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		queue_random_bytes(1'b0, 140);

		// mode flips in the middle of an unmasked payload
		make_frame(1'b0, OP_BINARY, LEN_SHORT, 20, 1'b0);
		send_frame_bytes(0, 10);
		write_expect_masked(1'b1);
		send_frame_bytes(10, frame_buf.size());
		queue_random_bytes(1'b1, 120);

		// a single fault ends the stream
		tail_masked = 1'($urandom_range(1));
		write_expect_masked(tail_masked);
		queue_fault(tail_masked);
		drain_results();

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ websocket_frame_deframer.f @@
rtl/core/wsdf_pkg.sv
rtl/core/wsdf_byte_if.sv
rtl/core/wsdf_result_if.sv
rtl/core/wsdf_parser.sv
rtl/core/websocket_frame_deframer.sv
tb/tb.sv
